// File: hdl/bpc_pkg.sv
// shared types and constants for the barometer pressure compensation block
package bpc_pkg;

	localparam int RawW   = 24;
	localparam int CoefW  = 16;
	localparam int TempW  = 19;
	localparam int PressW = 23;
	localparam int IdxW   = 3;

	// q = (D2 - tref*256) >>> 4 and the widths that follow from it
	localparam int QW     = 21;
	localparam int TProdW = 35;
	localparam int CProdW = 37;
	localparam int OffW   = 38;
	localparam int SensW  = 36;
	localparam int SensHW = 28;
	localparam int D1HW   = 16;
	localparam int PProdW = 45;

	localparam logic signed [TempW-1:0] TempBase = 19'sd2000;

	typedef enum logic [IdxW-1:0] {
		REG_SENS      = 3'd0,
		REG_OFFSET    = 3'd1,
		REG_SENS_TC   = 3'd2,
		REG_OFFSET_TC = 3'd3,
		REG_TREF      = 3'd4,
		REG_TEMPSENS  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [CoefW-1:0] sens;
		logic [CoefW-1:0] offset;
		logic [CoefW-1:0] sens_tc;
		logic [CoefW-1:0] offset_tc;
		logic [CoefW-1:0] tref;
		logic [CoefW-1:0] tempsens;
	} coef_t;

	typedef struct packed {
		logic signed [TempW-1:0]  temperature;
		logic signed [SensHW-1:0] sens_h;
		logic signed [OffW-1:0]   off;
		logic [D1HW-1:0]          d1h;
	} mid_t;

endpackage

// File: hdl/bpc_in_if.sv
// request channel carrying one pair of raw sensor readings
interface bpc_in_if import bpc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RawW-1:0]   raw_pressure;
	logic [RawW-1:0]   raw_temperature;

	modport source (output valid, raw_pressure, raw_temperature, input ready);
	modport sink (input valid, raw_pressure, raw_temperature, output ready);
endinterface

// File: hdl/bpc_out_if.sv
// result channel carrying one compensated temperature and pressure
interface bpc_out_if import bpc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [TempW-1:0]  temperature;
	logic signed [PressW-1:0] pressure;

	modport source (output valid, temperature, pressure, input ready);
	modport sink (input valid, temperature, pressure, output ready);
endinterface

// File: hdl/bpc_cfg.sv
// calibration coefficient registers
module bpc_cfg import bpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IdxW-1:0]  cfg_index,
	input  logic [CoefW-1:0] cfg_data,
	output coef_t            coef
);

	coef_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SENS:      coef_q.sens      <= cfg_data;
				REG_OFFSET:    coef_q.offset    <= cfg_data;
				REG_SENS_TC:   coef_q.sens_tc   <= cfg_data;
				REG_OFFSET_TC: coef_q.offset_tc <= cfg_data;
				REG_TREF:      coef_q.tref      <= cfg_data;
				REG_TEMPSENS:  coef_q.tempsens  <= cfg_data;
				default:       coef_q           <= coef_q;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

// File: hdl/bpc_front.sv
// stages 1 to 3: temperature difference, coefficient products, temperature, off and sens
module bpc_front import bpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	bpc_in_if.sink  in_ch,
	input  coef_t   coef,
	output logic    mid_valid,
	input  logic    mid_ready,
	output mid_t    mid
);

	logic go1, go2, go3;

	logic valid_s1, valid_s2, valid_s3;

	logic signed [QW-1:0]     q_s1;
	logic [D1HW-1:0]          d1h_s1;
	logic signed [TProdW-1:0] tprod_s2;
	logic signed [CProdW-1:0] oprod_s2;
	logic signed [CProdW-1:0] sprod_s2;
	logic [D1HW-1:0]          d1h_s2;
	mid_t                     mid_s3;

	logic signed [RawW:0]     dt;
	logic signed [OffW-1:0]   off_sum;
	logic signed [SensW-1:0]  sens_sum;

	// each stage moves when it is empty or the next one moves
	assign go3 = !valid_s3 || mid_ready;
	assign go2 = !valid_s2 || go3;
	assign go1 = !valid_s1 || go2;
	assign in_ch.ready = go1;

	assign dt = $signed({1'b0, in_ch.raw_temperature}) - $signed({1'b0, coef.tref, 8'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (go1) valid_s1 <= in_ch.valid;
			if (go2) valid_s2 <= valid_s1;
			if (go3) valid_s3 <= valid_s2;
		end
	end

	// floor shifts are part-selects of the signed value
	assign off_sum = $signed({5'b0, coef.offset, 17'b0})
		+ $signed({{3{oprod_s2[CProdW-1]}}, oprod_s2[CProdW-1:2]});
	assign sens_sum = $signed({4'b0, coef.sens, 16'b0})
		+ $signed({{2{sprod_s2[CProdW-1]}}, sprod_s2[CProdW-1:3]});

	always_ff @(posedge clk) begin
		if (go1 && in_ch.valid) begin
			q_s1   <= dt[RawW:4];
			d1h_s1 <= in_ch.raw_pressure[RawW-1:8];
		end
		if (go2 && valid_s1) begin
			tprod_s2 <= q_s1 * $signed({1'b0, coef.tempsens[CoefW-1:2]});
			oprod_s2 <= q_s1 * $signed({1'b0, coef.offset_tc});
			sprod_s2 <= q_s1 * $signed({1'b0, coef.sens_tc});
			d1h_s2   <= d1h_s1;
		end
		if (go3 && valid_s2) begin
			mid_s3.temperature <= $signed({tprod_s2[TProdW-1], tprod_s2[TProdW-1:17]})
				+ TempBase;
			mid_s3.off         <= off_sum;
			mid_s3.sens_h      <= sens_sum[SensW-1:8];
			mid_s3.d1h         <= d1h_s2;
		end
	end

	assign mid_valid = valid_s3;
	assign mid       = mid_s3;

endmodule

// File: hdl/bpc_back.sv
// stages 4 and 5: pressure product, offset subtract and output register
module bpc_back import bpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      mid_valid,
	output logic      mid_ready,
	input  mid_t      mid,
	bpc_out_if.source out_ch
);

	logic go4, go5;
	logic valid_s4, valid_s5;

	logic signed [PProdW-1:0] pprod_s4;
	logic signed [OffW-1:0]   off_s4;
	logic signed [TempW-1:0]  temp_s4;
	logic signed [TempW-1:0]  temp_s5;
	logic signed [PressW-1:0] press_s5;

	logic signed [OffW+2:0]   diff;

	assign go5 = !valid_s5 || out_ch.ready;
	assign go4 = !valid_s4 || go5;
	assign mid_ready = go4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (go4) valid_s4 <= mid_valid;
			if (go5) valid_s5 <= valid_s4;
		end
	end

	// (prod >>> 5) - off, then >>> 15 keeps the low result bits
	assign diff = $signed(pprod_s4[PProdW-1:5])
		- $signed({{3{off_s4[OffW-1]}}, off_s4});

	always_ff @(posedge clk) begin
		if (go4 && mid_valid) begin
			pprod_s4 <= mid.sens_h * $signed({1'b0, mid.d1h});
			off_s4   <= mid.off;
			temp_s4  <= mid.temperature;
		end
		if (go5 && valid_s4) begin
			temp_s5  <= temp_s4;
			press_s5 <= diff[PressW+14:15];
		end
	end

	assign out_ch.valid       = valid_s5;
	assign out_ch.temperature = temp_s5;
	assign out_ch.pressure    = press_s5;

endmodule

// File: hdl/barometer_pressure_compensation_top.sv
// top level of the first-order barometer pressure compensation pipeline
//
// in_ch takes one request per pair of raw 24-bit readings (pressure D1 and
// temperature D2); out_ch returns the compensated temperature in hundredths
// of a degree and the compensated pressure, one result per request, in order.
// The six calibration coefficients are loaded through cfg_we, cfg_index and
// cfg_data, one register per write; the user must load them while no request
// is in flight, as the block does not enforce it; writes to an index past the
// last register are dropped. Throughput is one request per cycle while the
// receiver holds ready high.
// The five stages are: temperature difference, three coefficient
// products, offset and sensitivity sums, the sensitivity times D1 product, and
// the offset subtract into the output register.
// Reset clears all coefficients and empties the pipeline. When the receiver
// holds ready low the result stays in the output register, and earlier stages
// keep filling until each holds a request; in_ch.ready then drops.
module barometer_pressure_compensation_top import bpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	bpc_in_if.sink           in_ch,
	bpc_out_if.source        out_ch,
	input  logic             cfg_we,
	input  logic [IdxW-1:0]  cfg_index,
	input  logic [CoefW-1:0] cfg_data
);

	coef_t coef;
	logic  mid_valid;
	logic  mid_ready;
	mid_t  mid;

	bpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	bpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.coef      (coef),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid       (mid)
	);

	bpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid       (mid),
		.out_ch    (out_ch)
	);

	// a free receiver never back-pressures the input
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.ready |-> in_ch.ready)
		else $error("input stalled while output ready");

	// writes outside the register list leave the coefficients alone
	a_cfg_ignore: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index != REG_SENS && cfg_index != REG_OFFSET
			&& cfg_index != REG_SENS_TC && cfg_index != REG_OFFSET_TC
			&& cfg_index != REG_TREF && cfg_index != REG_TEMPSENS) |=> $stable(coef))
		else $error("coefficient changed by out-of-range write");

	// a stalled request between the halves is not dropped
	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(mid_valid && !mid_ready) |=> (mid_valid && $stable(mid)))
		else $error("mid-pipeline request lost under stall");

endmodule
